@@ rtl/rgb_to_hsv_convert_defines.svh @@
// Assertion macros shared by the RGB-to-HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// Condition in this cycle implies consequence in the same cycle.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies consequence a fixed number of cycles later.
`define RHC_ASSERT_AFTER(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

@@ rtl/rgbhsv_pkg.sv @@
// Types and constants shared by the RGB-to-HSV converter.
`default_nettype none

package rgbhsv_pkg;

  localparam int COLOR_BITS = 8;
  localparam int FRAC_BITS  = 12;
  localparam int HUE_W      = FRAC_BITS + 3;
  localparam int SAT_W      = FRAC_BITS + 1;
  localparam int REM_W      = COLOR_BITS + 1;
  localparam int NUM_CELLS  = FRAC_BITS + 1;

  localparam logic [HUE_W-1:0] GREEN_BASE = HUE_W'(2 << FRAC_BITS);
  localparam logic [HUE_W-1:0] BLUE_BASE  = HUE_W'(4 << FRAC_BITS);
  localparam logic [HUE_W-1:0] FULL_TURN  = HUE_W'(6 << FRAC_BITS);
  localparam logic [SAT_W-1:0] SAT_ONE    = SAT_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]      hue;
    logic [SAT_W-1:0]      saturation;
    logic [COLOR_BITS-1:0] brightness;
    logic                  hue_defined;
  } hsv_t;

  // Word handed from cell to cell: two restoring dividers side by side.
  typedef struct packed {
    logic [REM_W-1:0]      sat_rem;
    logic [COLOR_BITS-1:0] sat_den;
    logic [SAT_W-1:0]      sat_q;
    logic [REM_W-1:0]      hue_rem;
    logic [COLOR_BITS-1:0] hue_den;
    logic [SAT_W-1:0]      hue_q;
    logic                  neg;
    sector_t               sector;
    logic                  black;
    logic                  flat;
    logic [COLOR_BITS-1:0] bright;
  } cell_word_t;

endpackage

`default_nettype wire

@@ rtl/rgbhsv_front.sv @@
// Input stage: max/min, sector select and divider operand setup.
`default_nettype none

module rgbhsv_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire rgbhsv_pkg::pixel_t    pixel,
  output logic                       valid,
  output rgbhsv_pkg::cell_word_t     word
);

  localparam int C = rgbhsv_pkg::COLOR_BITS;

  logic [C-1:0] r, g, b, mx, mn, d, mag;
  logic [C:0]   diff;
  rgbhsv_pkg::sector_t sector;
  rgbhsv_pkg::cell_word_t word_next;

  always_comb begin
    r  = pixel.red;
    g  = pixel.green;
    b  = pixel.blue;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    d = mx - mn;
    // ties go to red, then green
    if (mx == r) begin
      sector = rgbhsv_pkg::SEC_RED;
      diff   = {1'b0, g} - {1'b0, b};
    end else if (mx == g) begin
      sector = rgbhsv_pkg::SEC_GREEN;
      diff   = {1'b0, b} - {1'b0, r};
    end else begin
      sector = rgbhsv_pkg::SEC_BLUE;
      diff   = {1'b0, r} - {1'b0, g};
    end
    mag = diff[C] ? C'(-diff) : diff[C-1:0];

    word_next.sat_rem = {1'b0, d};
    word_next.sat_den = mx;
    word_next.sat_q   = '0;
    word_next.hue_rem = {1'b0, mag};
    word_next.hue_den = d;
    word_next.hue_q   = '0;
    word_next.neg     = diff[C];
    word_next.sector  = sector;
    word_next.black   = (mx == '0);
    word_next.flat    = (d == '0);
    word_next.bright  = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

@@ rtl/rgbhsv_cell.sv @@
// Divider cell: one quotient bit for saturation and for hue per stage.
`default_nettype none

module rgbhsv_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    valid_in,
  input  wire rgbhsv_pkg::cell_word_t  word_in,
  output logic                         valid,
  output rgbhsv_pkg::cell_word_t       word
);

  localparam int C = rgbhsv_pkg::COLOR_BITS;
  localparam int S = rgbhsv_pkg::SAT_W;

  logic sat_bit, hue_bit;
  logic [C:0] sat_left, hue_left;
  rgbhsv_pkg::cell_word_t word_next;

  always_comb begin
    word_next = word_in;
    sat_bit   = (word_in.sat_rem >= {1'b0, word_in.sat_den});
    hue_bit   = (word_in.hue_rem >= {1'b0, word_in.hue_den});
    sat_left  = sat_bit ? (word_in.sat_rem - {1'b0, word_in.sat_den}) : word_in.sat_rem;
    hue_left  = hue_bit ? (word_in.hue_rem - {1'b0, word_in.hue_den}) : word_in.hue_rem;
    // remainder is below the divisor here, so doubling fits
    word_next.sat_rem = {sat_left[C-1:0], 1'b0};
    word_next.hue_rem = {hue_left[C-1:0], 1'b0};
    word_next.sat_q   = {word_in.sat_q[S-2:0], sat_bit};
    word_next.hue_q   = {word_in.hue_q[S-2:0], hue_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

@@ rtl/rgbhsv_back.sv @@
// Output stage: floor correction, sector offset, wrap and result register.
`default_nettype none

module rgbhsv_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    valid_in,
  input  wire rgbhsv_pkg::cell_word_t  word_in,
  output logic                         done,
  output rgbhsv_pkg::hsv_t             result
);

  localparam int H = rgbhsv_pkg::HUE_W;

  logic [H-1:0] mag, base, hue_val;
  rgbhsv_pkg::hsv_t result_next;

  always_comb begin
    // a negative quotient rounds away from zero when the remainder is nonzero
    mag = H'(word_in.hue_q) + H'(word_in.neg && (word_in.hue_rem != '0));
    case (word_in.sector)
      rgbhsv_pkg::SEC_GREEN: base = rgbhsv_pkg::GREEN_BASE;
      rgbhsv_pkg::SEC_BLUE:  base = rgbhsv_pkg::BLUE_BASE;
      default:               base = word_in.neg ? rgbhsv_pkg::FULL_TURN : '0;
    endcase
    hue_val = word_in.neg ? (base - mag) : (base + mag);

    result_next.hue         = word_in.flat ? '0 : hue_val;
    result_next.saturation  = word_in.black ? '0 : word_in.sat_q;
    result_next.brightness  = word_in.bright;
    result_next.hue_defined = !word_in.flat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsv_convert.sv @@
// RGB-to-HSV converter top level: front stage, divider cell row, output stage.
// Throughput: one pixel per cycle; busy stays low, as every stage advances each cycle.
// The row has FRAC_BITS + 1 divider cells, one quotient bit per cell.
// Reset clears all valid flags; words in flight are dropped, and data registers are not reset.
`default_nettype none

`include "rgb_to_hsv_convert_defines.svh"

module rgb_to_hsv_convert (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire rgbhsv_pkg::pixel_t  pixel_in,
  output logic                     done,
  output rgbhsv_pkg::hsv_t         result
);

  localparam int N       = rgbhsv_pkg::NUM_CELLS;
  localparam int LATENCY = N + 2;

  logic                   valid [0:N];
  rgbhsv_pkg::cell_word_t word  [0:N];

  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .pixel  (pixel_in),
    .valid  (valid[0]),
    .word   (word[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .valid_in (valid[i]),
      .word_in  (word[i]),
      .valid    (valid[i+1]),
      .word     (word[i+1])
    );
  end

  rgbhsv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .valid_in (valid[N]),
    .word_in  (word[N]),
    .done     (done),
    .result   (result)
  );

  `RHC_ASSERT_AFTER(a_latency, start && !busy, LATENCY, done, "accepted word did not finish on time")
  `RHC_ASSERT_NOW(a_gray_hue, done && !result.hue_defined, result.hue == '0, "undefined hue not zero")
  `RHC_ASSERT_NOW(a_hue_range, done, result.hue < rgbhsv_pkg::FULL_TURN, "hue past a full turn")
  `RHC_ASSERT_NOW(a_sat_range, done, result.saturation <= rgbhsv_pkg::SAT_ONE, "saturation above one")

endmodule

`default_nettype wire

@@ tb/sv/rgb_to_hsv_convert_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RGB-to-HSV converter: predicts each pixel's HSV word and compares it.
module rgb_to_hsv_convert_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  rgbhsv_pkg::pixel_t  pixel_in,
  input  logic                done,
  input  rgbhsv_pkg::hsv_t    result,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);

  rgbhsv_pkg::hsv_t expected_hsv[$];

  // Signed division rounded toward minus infinity, den > 0.
  function automatic int floor_quot(input int num, input int den);
    if (num >= 0) begin
      return num / den;
    end
    return -((-num + den - 1) / den);
  endfunction

  function automatic rgbhsv_pkg::hsv_t hsv_of(input rgbhsv_pkg::pixel_t p);
    int                  unit;
    int                  r;
    int                  g;
    int                  b;
    int                  mx;
    int                  mn;
    int                  d;
    int                  h;
    int                  s;
    rgbhsv_pkg::sector_t sec;
    rgbhsv_pkg::hsv_t    o;
    unit = 1 << rgbhsv_pkg::FRAC_BITS;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    h = 0;
    s = 0;
    o.hue_defined = 1'b0;
    if (mx > 0) begin
      d = mx - mn;
      s = (unit * d) / mx;
      if (d > 0) begin
        o.hue_defined = 1'b1;
        // ties go to red, then green
        if (mx == r) sec = rgbhsv_pkg::SEC_RED;
        else if (mx == g) sec = rgbhsv_pkg::SEC_GREEN;
        else sec = rgbhsv_pkg::SEC_BLUE;
        case (sec)
          rgbhsv_pkg::SEC_RED: begin
            h = floor_quot(unit * (g - b), d);
            if (h < 0) h += 6 * unit;
          end
          rgbhsv_pkg::SEC_GREEN: h = 2 * unit + floor_quot(unit * (b - r), d);
          default:               h = 4 * unit + floor_quot(unit * (r - g), d);
        endcase
      end
    end
    o.hue        = rgbhsv_pkg::HUE_W'(h);
    o.saturation = rgbhsv_pkg::SAT_W'(s);
    o.brightness = rgbhsv_pkg::COLOR_BITS'(mx);
    return o;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    checked    = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    rgbhsv_pkg::hsv_t e;
    if (!rst) begin
      if (done) begin
        if (expected_hsv.size() == 0) begin
          $error("result word with no pixel outstanding: hue %0d sat %0d bright %0d",
                 result.hue, result.saturation, result.brightness);
          fail_count++;
        end else begin
          e = expected_hsv.pop_front();
          check_field("hue", e.hue, result.hue);
          check_field("saturation", e.saturation, result.saturation);
          check_field("brightness", e.brightness, result.brightness);
          check_field("hue_defined", e.hue_defined, result.hue_defined);
          checked++;
        end
      end
      if (start && !busy) begin
        expected_hsv.push_back(hsv_of(pixel_in));
      end
    end
    pending <= expected_hsv.size();
  end

endmodule

@@ tb/sv/rgb_to_hsv_convert_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the RGB-to-HSV converter: clock, reset, pixel stimulus and verdict.
module rgb_to_hsv_convert_tb;

  localparam int CB       = rgbhsv_pkg::COLOR_BITS;
  localparam int CMAX     = (1 << CB) - 1;
  localparam int N_RANDOM = 1950;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               start    = 1'b0;
  rgbhsv_pkg::pixel_t pixel_in = '0;
  logic               busy;
  logic               done;
  rgbhsv_pkg::hsv_t   result;

  int fail_count;
  int pending;
  int checked;
  int n_directed;
  int n_ties;
  int n_grays;

  always #4 clk = ~clk;

  rgb_to_hsv_convert u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .pixel_in (pixel_in),
    .done     (done),
    .result   (result)
  );

  rgb_to_hsv_convert_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_in   (pixel_in),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold start high until the word is taken; with may_idle set, drop it now and then after a pixel.
  task automatic send_pixel(input rgbhsv_pkg::pixel_t p, input bit may_idle);
    start    <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (busy);
    if (may_idle && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  function automatic logic [CB-1:0] corner_val();
    case ($urandom_range(3))
      0:       return '0;
      1:       return CB'(1);
      2:       return CB'(CMAX - 1);
      default: return CB'(CMAX);
    endcase
  endfunction

  initial begin
    rgbhsv_pkg::pixel_t dir_px[$];
    rgbhsv_pkg::pixel_t p;
    logic [CB-1:0]      v;
    int                 kind;
    n_directed = 0;
    n_ties     = 0;
    n_grays    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    dir_px.push_back({8'd0,   8'd0,   8'd0});    // black
    dir_px.push_back({8'd255, 8'd255, 8'd255});  // white
    dir_px.push_back({8'd128, 8'd128, 8'd128});  // mid gray
    dir_px.push_back({8'd1,   8'd1,   8'd1});    // dimmest gray
    dir_px.push_back({8'd255, 8'd0,   8'd0});
    dir_px.push_back({8'd0,   8'd255, 8'd0});
    dir_px.push_back({8'd0,   8'd0,   8'd255});
    dir_px.push_back({8'd255, 8'd255, 8'd0});    // red/green tie
    dir_px.push_back({8'd0,   8'd255, 8'd255});  // green/blue tie
    dir_px.push_back({8'd255, 8'd0,   8'd255});  // red/blue tie, hue wraps
    dir_px.push_back({8'd255, 8'd0,   8'd1});    // tiny negative red hue
    dir_px.push_back({8'd255, 8'd1,   8'd0});
    dir_px.push_back({8'd1,   8'd0,   8'd0});
    dir_px.push_back({8'd0,   8'd1,   8'd0});
    dir_px.push_back({8'd0,   8'd0,   8'd1});
    dir_px.push_back({8'd255, 8'd255, 8'd254});  // lowest nonzero saturation
    dir_px.push_back({8'd254, 8'd255, 8'd255});
    dir_px.push_back({8'd255, 8'd254, 8'd255});
    dir_px.push_back({8'd0,   8'd255, 8'd1});
    dir_px.push_back({8'd1,   8'd255, 8'd0});
    dir_px.push_back({8'd10,  8'd0,   8'd255});
    dir_px.push_back({8'd170, 8'd85,  8'd0});
    dir_px.push_back({8'd85,  8'd170, 8'd255});
    dir_px.push_back({8'd3,   8'd2,   8'd1});    // quotient with remainder
    dir_px.push_back({8'd2,   8'd3,   8'd1});
    foreach (dir_px[i]) begin
      send_pixel(dir_px[i], 1'b1);
      n_directed++;
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(99);
      p.red   = CB'($urandom_range(CMAX));
      p.green = CB'($urandom_range(CMAX));
      p.blue  = CB'($urandom_range(CMAX));
      v       = CB'($urandom_range(CMAX));
      if (kind < 50) begin
        // plain random pixel
      end else if (kind < 70) begin
        case ($urandom_range(2))
          0:       begin p.red   = v; p.green = v; end
          1:       begin p.green = v; p.blue  = v; end
          default: begin p.red   = v; p.blue  = v; end
        endcase
        n_ties++;
      end else if (kind < 78) begin
        p = {v, v, v};
        n_grays++;
      end else if (kind < 88) begin
        p = {corner_val(), corner_val(), corner_val()};
      end else begin
        // small channels give small divisors
        p = {CB'($urandom_range(7)), CB'($urandom_range(7)), CB'($urandom_range(7))};
      end
      send_pixel(p, !(i >= 800 && i < 1200));
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Drove %0d directed and %0d random pixels; %0d HSV words checked",
             n_directed, N_RANDOM, checked);
    $display("Random mix held %0d two-channel ties and %0d gray pixels", n_ties, n_grays);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
